FILE: src/tracking_wheel_odometry_top_defines.svh
// Assertion macros for the tracking-wheel odometry block.
// Used by tracking_wheel_odometry_top.sv; expects clk and arst_n in scope.
`ifndef TRACKING_WHEEL_ODOMETRY_TOP_DEFINES_SVH
`define TRACKING_WHEEL_ODOMETRY_TOP_DEFINES_SVH

// Condition holds in the same cycle as the trigger.
`define TWO_ASSERT_NOW(lbl, trig, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (prop)) \
		else $error(msg);

// Condition holds in the cycle after the trigger.
`define TWO_ASSERT_NEXT(lbl, trig, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (prop)) \
		else $error(msg);

`endif

FILE: src/two_pkg.sv
// Package for the tracking-wheel odometry block: constants, types, helpers.
// No dependencies; imported by tracking_wheel_odometry_top.
`default_nettype none

package two_pkg;

	localparam int ANGLE_BITS_DEF = 16;

	// Fixed-point constants (Q30)
	localparam logic [30:0] ONE_Q30     = 31'd1073741824;
	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
	localparam logic [32:0] TWO_PI_Q30  = 33'd6746518852;
	localparam logic [24:0] DEG_Q30     = 25'd18740330;
	localparam logic [31:0] HALF_TURN32 = 32'h8000_0000;

	// Series lengths and serial divider length
	localparam logic [2:0] SIN_LAST  = 3'd5;
	localparam logic [2:0] COS_LAST  = 3'd6;
	localparam int         DIV_STEPS = 64;
	localparam int         DCNT_W    = $clog2(DIV_STEPS + 1);

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_WHEEL_RADIUS = 2'd0,
		REG_FWD_OFFSET   = 2'd1,
		REG_SIDE_OFFSET  = 2'd2
	} reg_index_t;

	localparam logic [15:0] RADIUS_RST   = 16'd1408;
	localparam logic [15:0] FWD_OFF_RST  = 16'd3328;
	localparam logic [15:0] SIDE_OFF_RST = 16'd2048;

	typedef enum logic [4:0] {
		S_IDLE, S_START, S_D1, S_D2, S_D3, S_TH,
		S_SC0, S_SC1, S_SC2, S_SR0, S_SR1, S_SR2, S_SC3,
		S_Q0, S_Q1, S_Q2,
		S_L0, S_L1, S_L2, S_L3, S_L4,
		S_MEAN, S_ROT0, S_ROT1, S_ROT2, S_ROT3, S_ROT4,
		S_DONE, S_MWAIT, S_DWAIT
	} state_t;

	// Round half up and drop 30 fraction bits
	function automatic logic [33:0] rnd30(input logic [63:0] p);
		logic [63:0] s;
		s = p + 64'd536870912;
		return s[63:30];
	endfunction

	// Apply a sign to a rounded magnitude
	function automatic logic signed [34:0] sgnv(input logic [33:0] r, input logic neg);
		logic signed [34:0] v;
		v = $signed({1'b0, r});
		return neg ? -v : v;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		if (v > 36'sd2147483647)
			return 32'sh7FFF_FFFF;
		if (v < -36'sd2147483648)
			return 32'sh8000_0000;
		return v[31:0];
	endfunction

	// Encoder change, wrapped to 32 bits and limited to +-2^20
	function automatic logic signed [21:0] count_change(input logic [31:0] cur_v,
		input logic [31:0] prev_v);
		logic signed [31:0] d;
		d = $signed(cur_v - prev_v);
		if (d > 32'sd1048576)
			return 22'sd1048576;
		if (d < -32'sd1048576)
			return -22'sd1048576;
		return d[21:0];
	endfunction

	// Horner denominators of the sine and cosine series
	function automatic logic [7:0] series_den(input logic cos_sel, input logic [2:0] idx);
		logic [7:0] d;
		case ({cos_sel, idx})
			4'b0_000: d = 8'd6;
			4'b0_001: d = 8'd20;
			4'b0_010: d = 8'd42;
			4'b0_011: d = 8'd72;
			4'b0_100: d = 8'd110;
			4'b0_101: d = 8'd156;
			4'b1_000: d = 8'd2;
			4'b1_001: d = 8'd12;
			4'b1_010: d = 8'd30;
			4'b1_011: d = 8'd56;
			4'b1_100: d = 8'd90;
			4'b1_101: d = 8'd132;
			4'b1_110: d = 8'd182;
			default:  d = 8'd1;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

FILE: src/tracking_wheel_odometry_top.sv
// Tracking-wheel odometry: sequencer with a digit-serial multiplier and divider.
// Depends on two_pkg and tracking_wheel_odometry_top_defines.svh.
//
// Usage:
//  Input channel (in_valid/in_ready) takes one sample: forward_count,
//  sideways_count (degrees) and imu_heading (clockwise binary angle).
//  Output channel (out_valid/out_ready) returns one result per sample:
//  pos_x, pos_y (1/1024 inch, saturating) and orientation (counterclockwise).
//  Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//  wheel radius and the two wheel offsets; cfg_ready is always high.
//  The first sample after reset only primes the stored readings and
//  returns without computing. A later sample runs up to 27 divides in the
//  bit-serial divider and up to 45 products in the 4-bit-per-cycle
//  multiplier.
//  One sample is processed at a time; a new request is taken while the
//  previous result still waits in the output register.
//  If the receiver stalls, the finished sample holds in the final state
//  until the output register frees up.
//  Reset clears position, stored readings and the primed flag, and loads
//  the configuration defaults.
`default_nettype none
`include "tracking_wheel_odometry_top_defines.svh"

module tracking_wheel_odometry_top #(
	parameter int ANGLE_BITS = two_pkg::ANGLE_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic signed [31:0]  forward_count,
	input  wire logic signed [31:0]  sideways_count,
	input  wire logic        [15:0]  imu_heading,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic signed      [31:0]  pos_x,
	output logic signed      [31:0]  pos_y,
	output logic             [15:0]  orientation,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire two_pkg::reg_index_t cfg_index,
	input  wire logic        [15:0]  cfg_data
);
	import two_pkg::*;

	localparam int AB = ANGLE_BITS;

	// Control state
	state_t state_q, state_d, ret_q, ret_d;
	logic   primed_q, out_valid_q, done_fire;

	// Configuration
	logic        [15:0] radius_q;
	logic signed [15:0] fwd_off_q, side_off_q;

	// Stored readings and position
	logic [31:0]        last_fwd_q, last_side_q;
	logic [AB-1:0]      last_ori_q;
	logic signed [31:0] acc_x_q, acc_y_q;

	// Sample and working registers
	logic [31:0]        fwd_q, side_q;
	logic [AB-1:0]      orient_q, du_q;
	logic signed [21:0] dcf_q, dcs_q;
	logic               wsel_q, sc_ret_q, cos_q;
	logic signed [31:0] dl_q, ds_q, s_q, c_q;
	logic [31:0]        ang_q, x2_q, q_q, cq_q;
	logic [30:0]        x_q, t_q, sv_q;
	logic [2:0]         idx_q;
	logic signed [34:0] mt_q, lx_q, ly_q, dx_q;

	// Output register
	logic signed [31:0] pos_x_q, pos_y_q;
	logic [15:0]        ori_out_q;

	// Multiplier
	logic        mul_go;
	logic [39:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mc_q, mac_q, digit_prod;
	logic [31:0] mp_q;

	// Divider
	logic              div_go;
	logic [63:0]       div_n, dvd_q;
	logic [31:0]       div_d, dvs_q, rem_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic [32:0]       rem_sh, rem_nx;
	logic              rem_ge;

	// Derived values
	logic [AB+15:0]     head_wide;
	logic [AB-1:0]      orient_in, mag;
	logic [AB+15:0]     ori_wide;
	logic               neg;
	logic [33:0]        rn_prod, rn_quo;
	logic signed [21:0] dsel;
	logic [21:0]        dsel_mag;
	logic [31:0]        ds_mag, dl_mag, s_mag, c_mag;
	logic [15:0]        fo_mag, so_mag;
	logic [34:0]        lx_mag, ly_mag;
	logic signed [35:0] tn;
	logic [30:0]        t_next, sv_next;
	logic [31:0]        mean, half_ang, rad_calc;
	logic [63:0]        rsum, c_dvd;
	logic signed [34:0] dy;
	logic signed [31:0] fs, fc;

	assign cfg_ready   = 1'b1;
	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign pos_x       = pos_x_q;
	assign pos_y       = pos_y_q;
	assign orientation = ori_out_q;

	// Heading to counterclockwise orientation
	assign head_wide = {{AB{1'b0}}, imu_heading};
	assign orient_in = {AB{1'b0}} - head_wide[AB-1:0];
	assign ori_wide  = {16'b0, orient_q};

	// Heading change and magnitudes
	assign neg      = du_q[AB-1];
	assign mag      = neg ? ({AB{1'b0}} - du_q) : du_q;
	assign dsel     = wsel_q ? dcs_q : dcf_q;
	assign dsel_mag = dsel[21] ? (22'd0 - dsel) : dsel;
	assign ds_mag   = ds_q[31] ? (32'd0 - ds_q) : ds_q;
	assign dl_mag   = dl_q[31] ? (32'd0 - dl_q) : dl_q;
	assign s_mag    = s_q[31] ? (32'd0 - s_q) : s_q;
	assign c_mag    = c_q[31] ? (32'd0 - c_q) : c_q;
	assign fo_mag   = fwd_off_q[15] ? (16'd0 - fwd_off_q) : fwd_off_q;
	assign so_mag   = side_off_q[15] ? (16'd0 - side_off_q) : side_off_q;
	assign lx_mag   = lx_q[34] ? (35'd0 - lx_q) : lx_q;
	assign ly_mag   = ly_q[34] ? (35'd0 - ly_q) : ly_q;

	assign rn_prod = rnd30(mac_q);
	assign rn_quo  = rnd30(dvd_q);

	// Horner step result, clamped at zero
	assign tn      = $signed({5'b0, ONE_Q30}) - $signed({2'b0, rn_quo});
	assign t_next  = tn[35] ? 31'd0 : tn[30:0];
	assign sv_next = (rn_prod > 34'(ONE_Q30)) ? ONE_Q30 : rn_prod[30:0];

	// Quadrant fold of sine and cosine
	always_comb begin
		case (ang_q[31:30])
			2'd0: begin
				fs = $signed({1'b0, sv_q});
				fc = $signed({1'b0, t_next});
			end
			2'd1: begin
				fs = $signed({1'b0, t_next});
				fc = -$signed({1'b0, sv_q});
			end
			2'd2: begin
				fs = -$signed({1'b0, sv_q});
				fc = -$signed({1'b0, t_next});
			end
			default: begin
				fs = -$signed({1'b0, t_next});
				fc = $signed({1'b0, sv_q});
			end
		endcase
	end

	// Angles on a 2^32 per turn scale
	assign half_ang = {1'b0, mag, {(31-AB){1'b0}}};
	assign mean = {last_ori_q, {(32-AB){1'b0}}} + {1'b0, du_q, {(31-AB){1'b0}}}
		- (neg ? HALF_TURN32 : 32'd0);

	// Heading change in radians and the chord-to-arc dividend
	assign rsum     = mac_q + (64'd1 << (AB - 1));
	assign rad_calc = rsum[AB +: 32];
	assign c_dvd    = {2'b0, q_q, 30'b0} + {33'b0, rad_calc[31:1]};

	assign dy = mt_q + sgnv(rn_prod, lx_q[34] ^ c_q[31]);

	assign done_fire = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// Next state and unit launches
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		mul_go  = 1'b0;
		mul_a   = '0;
		mul_b   = '0;
		div_go  = 1'b0;
		div_n   = '0;
		div_d   = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid)
					state_d = S_START;
			end
			S_START: state_d = primed_q ? S_D1 : S_DONE;
			S_D1: begin
				mul_go = 1'b1; mul_a = 40'(dsel_mag); mul_b = 32'(radius_q);
				state_d = S_MWAIT; ret_d = S_D2;
			end
			S_D2: begin
				mul_go = 1'b1; mul_a = mac_q[39:0]; mul_b = 32'(DEG_Q30);
				state_d = S_MWAIT; ret_d = S_D3;
			end
			S_D3: state_d = wsel_q ? S_TH : S_D1;
			S_TH: state_d = (du_q == '0) ? S_MEAN : S_SC0;
			S_SC0: begin
				mul_go = 1'b1; mul_a = 40'(ang_q[29:0]); mul_b = 32'(HALF_PI_Q30);
				state_d = S_MWAIT; ret_d = S_SC1;
			end
			S_SC1: begin
				mul_go = 1'b1; mul_a = 40'(rn_prod[30:0]); mul_b = 32'(rn_prod[30:0]);
				state_d = S_MWAIT; ret_d = S_SC2;
			end
			S_SC2: state_d = S_SR0;
			S_SR0: begin
				mul_go = 1'b1; mul_a = 40'(x2_q); mul_b = 32'(t_q);
				state_d = S_MWAIT; ret_d = S_SR1;
			end
			S_SR1: begin
				div_go = 1'b1; div_n = mac_q; div_d = 32'(series_den(cos_q, idx_q));
				state_d = S_DWAIT; ret_d = S_SR2;
			end
			S_SR2: begin
				if (idx_q != 3'd0) begin
					state_d = S_SR0;
				end else if (!cos_q) begin
					mul_go = 1'b1; mul_a = 40'(x_q); mul_b = 32'(t_next);
					state_d = S_MWAIT; ret_d = S_SC3;
				end else begin
					state_d = sc_ret_q ? S_ROT0 : S_Q0;
				end
			end
			S_SC3: state_d = S_SR0;
			S_Q0: begin
				mul_go = 1'b1; mul_a = 40'(TWO_PI_Q30); mul_b = 32'(mag);
				state_d = S_MWAIT; ret_d = S_Q1;
			end
			S_Q1: begin
				div_go = 1'b1; div_n = c_dvd; div_d = rad_calc;
				state_d = S_DWAIT; ret_d = S_Q2;
			end
			S_Q2: state_d = S_L0;
			S_L0: begin
				mul_go = 1'b1; mul_a = 40'(ds_mag); mul_b = cq_q;
				state_d = S_MWAIT; ret_d = S_L1;
			end
			S_L1: begin
				mul_go = 1'b1; mul_a = 40'(so_mag); mul_b = q_q;
				state_d = S_MWAIT; ret_d = S_L2;
			end
			S_L2: begin
				mul_go = 1'b1; mul_a = 40'(dl_mag); mul_b = cq_q;
				state_d = S_MWAIT; ret_d = S_L3;
			end
			S_L3: begin
				mul_go = 1'b1; mul_a = 40'(fo_mag); mul_b = q_q;
				state_d = S_MWAIT; ret_d = S_L4;
			end
			S_L4: state_d = S_MEAN;
			S_MEAN: state_d = S_SC0;
			S_ROT0: begin
				mul_go = 1'b1; mul_a = 40'(ly_mag); mul_b = c_mag;
				state_d = S_MWAIT; ret_d = S_ROT1;
			end
			S_ROT1: begin
				mul_go = 1'b1; mul_a = 40'(lx_mag); mul_b = s_mag;
				state_d = S_MWAIT; ret_d = S_ROT2;
			end
			S_ROT2: begin
				mul_go = 1'b1; mul_a = 40'(ly_mag); mul_b = s_mag;
				state_d = S_MWAIT; ret_d = S_ROT3;
			end
			S_ROT3: begin
				mul_go = 1'b1; mul_a = 40'(lx_mag); mul_b = c_mag;
				state_d = S_MWAIT; ret_d = S_ROT4;
			end
			S_ROT4: state_d = S_DONE;
			S_DONE: begin
				if (done_fire)
					state_d = S_IDLE;
			end
			S_MWAIT: begin
				if (mp_q == '0)
					state_d = ret_q;
			end
			S_DWAIT: begin
				if (dcnt_q == '0)
					state_d = ret_q;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State, configuration, position and handshake registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			primed_q    <= 1'b0;
			out_valid_q <= 1'b0;
			radius_q    <= RADIUS_RST;
			fwd_off_q   <= FWD_OFF_RST;
			side_off_q  <= SIDE_OFF_RST;
			last_fwd_q  <= '0;
			last_side_q <= '0;
			last_ori_q  <= '0;
			acc_x_q     <= '0;
			acc_y_q     <= '0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			if (cfg_valid) begin
				case (cfg_index)
					REG_WHEEL_RADIUS: radius_q   <= cfg_data;
					REG_FWD_OFFSET:   fwd_off_q  <= cfg_data;
					REG_SIDE_OFFSET:  side_off_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == S_ROT4) begin
				acc_x_q <= sat32(36'(acc_x_q) + 36'(dx_q));
				acc_y_q <= sat32(36'(acc_y_q) + 36'(dy));
			end
			if (done_fire) begin
				last_fwd_q  <= fwd_q;
				last_side_q <= side_q;
				last_ori_q  <= orient_q;
				primed_q    <= 1'b1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers of the sequencer
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					fwd_q    <= forward_count;
					side_q   <= sideways_count;
					orient_q <= orient_in;
				end
			end
			S_START: begin
				dcf_q  <= count_change(fwd_q, last_fwd_q);
				dcs_q  <= count_change(side_q, last_side_q);
				du_q   <= orient_q - last_ori_q;
				wsel_q <= 1'b0;
			end
			S_D3: begin
				if (wsel_q)
					ds_q <= 32'(sgnv(rn_prod, dsel[21]));
				else
					dl_q <= 32'(sgnv(rn_prod, dsel[21]));
				wsel_q <= 1'b1;
			end
			S_TH: begin
				lx_q     <= 35'(ds_q);
				ly_q     <= 35'(dl_q);
				ang_q    <= half_ang;
				sc_ret_q <= 1'b0;
			end
			S_SC1: x_q <= rn_prod[30:0];
			S_SC2: begin
				x2_q  <= rn_prod[31:0];
				t_q   <= ONE_Q30;
				idx_q <= SIN_LAST;
				cos_q <= 1'b0;
			end
			S_SR2: begin
				t_q   <= t_next;
				idx_q <= idx_q - 3'd1;
				s_q   <= fs;
				c_q   <= fc;
			end
			S_SC3: begin
				sv_q  <= sv_next;
				t_q   <= ONE_Q30;
				idx_q <= COS_LAST;
				cos_q <= 1'b1;
			end
			S_Q0: q_q <= {s_q[30:0], 1'b0};
			S_Q2: cq_q <= dvd_q[31:0];
			S_L1: mt_q <= sgnv(rn_prod, ds_q[31]);
			S_L2: lx_q <= mt_q + sgnv(rn_prod, side_off_q[15] ^ neg);
			S_L3: mt_q <= sgnv(rn_prod, dl_q[31]);
			S_L4: ly_q <= mt_q + sgnv(rn_prod, fwd_off_q[15] ^ neg);
			S_MEAN: begin
				ang_q    <= mean;
				sc_ret_q <= 1'b1;
			end
			S_ROT1: mt_q <= sgnv(rn_prod, ly_q[34] ^ c_q[31]);
			S_ROT2: dx_q <= mt_q - sgnv(rn_prod, lx_q[34] ^ s_q[31]);
			S_ROT3: mt_q <= sgnv(rn_prod, ly_q[34] ^ s_q[31]);
			S_DONE: begin
				if (done_fire) begin
					pos_x_q   <= acc_x_q;
					pos_y_q   <= acc_y_q;
					ori_out_q <= ori_wide[15:0];
				end
			end
			default: ;
		endcase
	end

	// Multiplier: one 4-bit digit of the multiplier per cycle
	assign digit_prod = (mp_q[0] ? mc_q : 64'd0) + (mp_q[1] ? (mc_q << 1) : 64'd0)
		+ (mp_q[2] ? (mc_q << 2) : 64'd0) + (mp_q[3] ? (mc_q << 3) : 64'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mp_q <= '0;
		end else if (mul_go) begin
			mp_q <= mul_b;
		end else if (mp_q != '0) begin
			mp_q <= mp_q >> 4;
		end
	end

	always_ff @(posedge clk) begin
		if (mul_go) begin
			mc_q  <= 64'(mul_a);
			mac_q <= '0;
		end else if (mp_q != '0) begin
			mc_q  <= mc_q << 4;
			mac_q <= mac_q + digit_prod;
		end
	end

	// Divider: restoring, one quotient bit per cycle, quotient shifts into dvd_q
	assign rem_sh = {rem_q, dvd_q[63]};
	assign rem_ge = (rem_sh >= {1'b0, dvs_q});
	assign rem_nx = rem_ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (div_go) begin
			dcnt_q <= DCNT_W'(DIV_STEPS);
		end else if (dcnt_q != '0) begin
			dcnt_q <= dcnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (div_go) begin
			dvd_q <= div_n;
			dvs_q <= div_d;
			rem_q <= '0;
		end else if (dcnt_q != '0) begin
			dvd_q <= {dvd_q[62:0], rem_ge};
			rem_q <= rem_nx[31:0];
		end
	end

	// Checks
	`TWO_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready, "request taken while busy")
	`TWO_ASSERT_NOW(a_mul_free, mul_go, mp_q == '0, "multiplier restarted while running")
	`TWO_ASSERT_NOW(a_div_free, div_go, dcnt_q == '0, "divider restarted while running")

endmodule

`default_nettype wire
